// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/frs_pkg.sv -----
// ----------------------------------------------------------------------------
// frs_pkg
// Types and fixed widths of the Fenwick rank/select block.
// ----------------------------------------------------------------------------
package frs_pkg;

   localparam int COUNT_W  = 17;
   localparam int BUCKET_W = 11;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_MOVE   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_CHK,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_UPD_NEXT,
      ST_SRCH,
      ST_QRY
   } state_type;

   // Query sub-step: issue a node read, then accumulate it.
   typedef enum logic {
      QS_ISSUE,
      QS_ACC
   } qstep_type;

endpackage

// ----- rtl/core/fenwick_rank_select.sv -----
// ----------------------------------------------------------------------------
// fenwick_rank_select
// Fenwick tree of per-bucket element counts with a threshold rank search.
// ----------------------------------------------------------------------------
// Usage: pulse start with req_type, req_old_bucket and req_new_bucket while
// busy is low. An insert adds one to req_new_bucket and gives no result. A
// move takes one from req_old_bucket, adds one to req_new_bucket, then binary
// searches for the largest bucket prefix whose count does not exceed the
// threshold written through csr_wr_en/csr_wr_data. That prefix count appears
// on rsp_prefix_count for one cycle with rsp_valid high, in the first cycle
// that busy is low again; the receiver cannot stall it. Buckets of zero or
// above NUM_BUCKETS skip their update.
// Structure: all tree nodes sit in one memory with a registered read, and one
// saturating adder sums them for queries. An update walks up to
// log2(NUM_BUCKETS)+1 nodes; a search makes up to log2(N)+2 prefix queries,
// each reading one node per set bit of the queried prefix. One transaction
// is in flight at a time.
// Reset: a clearing pass writes every node to zero with busy high; the
// threshold resets to zero and may be written meanwhile.
// ----------------------------------------------------------------------------
module fenwick_rank_select #(
   parameter int NUM_BUCKETS = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [frs_pkg::BUCKET_W-1:0]  req_old_bucket,
   input  logic [frs_pkg::BUCKET_W-1:0]  req_new_bucket,
   output logic                          rsp_valid,
   output logic [frs_pkg::COUNT_W-1:0]   rsp_prefix_count,
   input  logic                          csr_wr_en,
   input  logic [frs_pkg::COUNT_W-1:0]   csr_wr_data
);

   localparam int AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int IW = AW + 1;
   localparam int CW = frs_pkg::COUNT_W;
   localparam logic [IW-1:0] N_IDX   = IW'(NUM_BUCKETS);
   localparam logic [IW:0]   N_WIDE  = (IW+1)'(NUM_BUCKETS);
   localparam logic [AW-1:0] LAST_AD = AW'(NUM_BUCKETS - 1);

   // Node storage, index i of the tree at address i-1.
   logic [CW-1:0] count_mem_ff [NUM_BUCKETS];
   logic [CW-1:0] rd_data_ff;

   frs_pkg::state_type state_ff, state_in;
   frs_pkg::qstep_type qstep_ff, qstep_in;

   logic [CW-1:0] thr_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic          move_ff, move_in;
   logic          up_ff, up_in;
   logic          cur_ok_ff, cur_ok_in;
   logic          new_ok_ff, new_ok_in;
   logic [IW-1:0] new_ff, new_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [IW-1:0] lo_ff, lo_in;
   logic [IW-1:0] hi_ff, hi_in;
   logic [IW-1:0] qk_ff, qk_in;
   logic [IW-1:0] qi_ff, qi_in;
   logic          final_ff, final_in;
   logic [CW-1:0] sum_ff, sum_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] rsp_count_ff, rsp_count_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [CW-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;

   logic          old_ok, new_ok;
   logic [IW-1:0] idx_m1, qi_m1, lowbit, span, probe;
   logic [IW:0]   idx_next;
   logic [CW:0]   sum_wide;
   logic [CW-1:0] sum_sat, node_upd;

   assign old_ok = (req_old_bucket != '0) && (32'(req_old_bucket) <= NUM_BUCKETS);
   assign new_ok = (req_new_bucket != '0) && (32'(req_new_bucket) <= NUM_BUCKETS);

   assign idx_m1   = idx_ff - 1'b1;
   assign qi_m1    = qi_ff - 1'b1;
   assign lowbit   = idx_ff & (~idx_ff + 1'b1);
   assign idx_next = {1'b0, idx_ff} + {1'b0, lowbit};
   assign span     = hi_ff - lo_ff + 1'b1;
   assign probe    = lo_ff + (span >> 1);

   // The one shared saturating adder.
   assign sum_wide = {1'b0, sum_ff} + {1'b0, rd_data_ff};
   assign sum_sat  = sum_wide[CW] ? frs_pkg::COUNT_MAX : sum_wide[CW-1:0];

   always_comb begin
      if (up_ff) begin
         node_upd = (rd_data_ff == frs_pkg::COUNT_MAX) ? rd_data_ff : rd_data_ff + 1'b1;
      end else begin
         node_upd = (rd_data_ff == '0) ? rd_data_ff : rd_data_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= count_mem_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frs_pkg::ST_CLEAR;
         qstep_ff     <= frs_pkg::QS_ISSUE;
         clr_ff       <= '0;
         thr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         qstep_ff     <= qstep_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_count_ff <= rsp_count_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      move_ff      <= move_in;
      up_ff        <= up_in;
      cur_ok_ff    <= cur_ok_in;
      new_ok_ff    <= new_ok_in;
      new_ff       <= new_in;
      idx_ff       <= idx_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      qk_ff        <= qk_in;
      qi_ff        <= qi_in;
      final_ff     <= final_in;
      sum_ff       <= sum_in;
   end

   always_comb begin
      state_in     = state_ff;
      qstep_in     = qstep_ff;
      clr_in       = clr_ff;
      move_in      = move_ff;
      up_in        = up_ff;
      cur_ok_in    = cur_ok_ff;
      new_ok_in    = new_ok_ff;
      new_in       = new_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      qk_in        = qk_ff;
      qi_in        = qi_ff;
      final_in     = final_ff;
      sum_in       = sum_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_m1[AW-1:0];
      mem_wdata    = node_upd;
      mem_raddr    = idx_m1[AW-1:0];

      case (state_ff)
         frs_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_AD) begin
               state_in = frs_pkg::ST_IDLE;
            end
         end
         frs_pkg::ST_IDLE: begin
            if (start) begin
               move_in   = (req_type == frs_pkg::REQ_MOVE);
               new_in    = IW'(req_new_bucket);
               new_ok_in = new_ok;
               if (req_type == frs_pkg::REQ_MOVE) begin
                  idx_in    = IW'(req_old_bucket);
                  up_in     = 1'b0;
                  cur_ok_in = old_ok;
               end else begin
                  idx_in    = IW'(req_new_bucket);
                  up_in     = 1'b1;
                  cur_ok_in = new_ok;
               end
               state_in = frs_pkg::ST_UPD_CHK;
            end
         end
         frs_pkg::ST_UPD_CHK: begin
            state_in = cur_ok_ff ? frs_pkg::ST_UPD_RD : frs_pkg::ST_UPD_NEXT;
         end
         frs_pkg::ST_UPD_RD: begin
            state_in = frs_pkg::ST_UPD_WR;
         end
         frs_pkg::ST_UPD_WR: begin
            mem_we = 1'b1;
            idx_in = idx_next[IW-1:0];
            state_in = (idx_next > N_WIDE) ? frs_pkg::ST_UPD_NEXT : frs_pkg::ST_UPD_RD;
         end
         frs_pkg::ST_UPD_NEXT: begin
            if (!up_ff) begin
               idx_in    = new_ff;
               up_in     = 1'b1;
               cur_ok_in = new_ok_ff;
               state_in  = frs_pkg::ST_UPD_CHK;
            end else if (move_ff) begin
               lo_in    = '0;
               hi_in    = N_IDX;
               final_in = 1'b0;
               state_in = frs_pkg::ST_SRCH;
            end else begin
               state_in = frs_pkg::ST_IDLE;
            end
         end
         frs_pkg::ST_SRCH: begin
            // lo is the longest prefix known to fit, hi the longest that may.
            if (lo_ff != hi_ff) begin
               qk_in = probe;
               qi_in = probe;
            end else begin
               qk_in    = lo_ff;
               qi_in    = lo_ff;
               final_in = 1'b1;
            end
            sum_in   = '0;
            qstep_in = frs_pkg::QS_ISSUE;
            state_in = frs_pkg::ST_QRY;
         end
         frs_pkg::ST_QRY: begin
            mem_raddr = qi_m1[AW-1:0];
            case (qstep_ff)
               frs_pkg::QS_ISSUE: begin
                  if (qi_ff != '0) begin
                     qstep_in = frs_pkg::QS_ACC;
                  end else if (final_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_count_in = sum_ff;
                     state_in     = frs_pkg::ST_IDLE;
                  end else begin
                     if (sum_ff <= thr_ff) begin
                        lo_in = qk_ff;
                     end else begin
                        hi_in = qk_ff - 1'b1;
                     end
                     state_in = frs_pkg::ST_SRCH;
                  end
               end
               frs_pkg::QS_ACC: begin
                  sum_in   = sum_sat;
                  qi_in    = qi_ff & qi_m1;
                  qstep_in = frs_pkg::QS_ISSUE;
               end
               default: begin
                  qstep_in = frs_pkg::QS_ISSUE;
               end
            endcase
         end
         default: begin
            state_in = frs_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != frs_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prefix_count = rsp_count_ff;

endmodule

// ----- rtl/core/frs_checker.sv -----
// ----------------------------------------------------------------------------
// frs_checker
// Port-level checks of the Fenwick rank/select block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [frs_pkg::COUNT_W-1:0] rsp_prefix_count
);

   // A result is a single-cycle strobe.
   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)

   // A result appears only once the block has finished its transaction.
   `ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy)

   // A result follows a busy period; it never appears out of nowhere.
   `ASSERT_SAME(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))

   // An accepted transaction makes the block busy in the next cycle.
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // While the block idles with no new transaction, the reported count holds.
   `ASSERT_NEXT(a_count_hold, clock, reset, !busy && !start, $stable(rsp_prefix_count))

endmodule

bind fenwick_rank_select frs_checker u_frs_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_prefix_count (rsp_prefix_count)
);

// ----- test/tb_fenwick_rank_select.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fenwick_rank_select
// Self-checking bench for the Fenwick rank/select block. Inserts and moves are
// sent through the start/busy command port, while a bit-accurate copy of the
// count tree predicts each threshold search. Every reported prefix count is
// checked in order against those predictions. The threshold changes between
// phases, and a final phase crowds two buckets with back-to-back inserts.
// ----------------------------------------------------------------------------
module tb_fenwick_rank_select;

   localparam int NUM_BUCKETS = 1024;
   localparam int DRAIN_PAD   = 64;
   localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;
   localparam int COUNT_W     = frs_pkg::COUNT_W;
   localparam int BUCKET_W    = frs_pkg::BUCKET_W;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_type = frs_pkg::REQ_INSERT;
   logic [BUCKET_W-1:0]  req_old_bucket = '0;
   logic [BUCKET_W-1:0]  req_new_bucket = '0;
   logic                 rsp_valid;
   logic [COUNT_W-1:0]   rsp_prefix_count;
   logic                 csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]   csr_wr_data = '0;

   fenwick_rank_select #(.NUM_BUCKETS(NUM_BUCKETS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_old_bucket   (req_old_bucket),
      .req_new_bucket   (req_new_bucket),
      .rsp_valid        (rsp_valid),
      .rsp_prefix_count (rsp_prefix_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the count tree and the threshold register.
   logic [COUNT_W-1:0] fen_nodes [1:NUM_BUCKETS];
   logic [COUNT_W-1:0] threshold_q = '0;
   logic [COUNT_W-1:0] exp_prefix_q [$];
   logic [COUNT_W-1:0] wanted;
   int                 elem_q [$];   // bucket of each tracked element
   int                 err_count = 0;
   bit                 gapless = 1'b0;
   longint unsigned    cycle_count = 0;

   task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] seen,
                                  input logic [COUNT_W-1:0] want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, seen, want);
      err_count++;
   endtask

   function automatic void tree_bump(input logic [BUCKET_W-1:0] bucket, input bit up);
      int i;
      if (bucket == 0 || int'(bucket) > NUM_BUCKETS)
         return;
      for (i = int'(bucket); i <= NUM_BUCKETS; i += i & (-i)) begin
         if (up) begin
            if (fen_nodes[i] != frs_pkg::COUNT_MAX)
               fen_nodes[i] = fen_nodes[i] + 1'b1;
         end else begin
            if (fen_nodes[i] != '0)
               fen_nodes[i] = fen_nodes[i] - 1'b1;
         end
      end
   endfunction

   function automatic int prefix_total(input int k);
      int acc;
      int i;
      acc = 0;
      if (k > NUM_BUCKETS)
         k = NUM_BUCKETS;
      for (i = k; i != 0; i -= i & (-i)) begin
         acc += int'(fen_nodes[i]);
         if (acc > int'(frs_pkg::COUNT_MAX))
            acc = int'(frs_pkg::COUNT_MAX);
      end
      return acc;
   endfunction

   // Binary search as the block does it, even where the sums are not monotone.
   function automatic logic [COUNT_W-1:0] rank_search();
      int lo;
      int hi;
      int mid;
      lo = -1;
      hi = NUM_BUCKETS;
      while (lo + 1 != hi) begin
         mid = lo + (hi - lo) / 2;
         if (prefix_total(mid + 1) <= int'(threshold_q))
            lo = mid;
         else
            hi = mid;
      end
      return COUNT_W'(prefix_total(lo + 1));
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (gapless || r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(20, 300);
   endfunction

   task automatic send_req(input logic kind, input logic [BUCKET_W-1:0] from_b,
                           input logic [BUCKET_W-1:0] to_b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= kind;
      req_old_bucket <= from_b;
      req_new_bucket <= to_b;
      do @(posedge clock); while (busy !== 1'b0);
      if (kind == frs_pkg::REQ_MOVE) begin
         tree_bump(from_b, 1'b0);
         tree_bump(to_b, 1'b1);
         exp_prefix_q = {exp_prefix_q, rank_search()};
      end else begin
         tree_bump(to_b, 1'b1);
      end
   endtask

   // An insert gives no result, so after the last result the block may still
   // be updating the tree; pad past its latency before touching the register.
   task automatic wait_drained();
      start <= 1'b0;
      while (exp_prefix_q.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [COUNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      threshold_q = value;
   endtask

   task automatic test_insert_and_move();
      // Threshold zero: a non-empty first bucket gives a zero count.
      send_req(frs_pkg::REQ_INSERT, 11'd0, 11'd1);
      send_req(frs_pkg::REQ_INSERT, 11'd2047, 11'd1024);
      send_req(frs_pkg::REQ_MOVE, 11'd1, 11'd1);
      send_req(frs_pkg::REQ_MOVE, 11'd1024, 11'd1024);
      wait_drained();
      write_threshold(17'd65536);
      send_req(frs_pkg::REQ_MOVE, 11'd1024, 11'd1);
      send_req(frs_pkg::REQ_INSERT, 11'd3, 11'd2);
      send_req(frs_pkg::REQ_MOVE, 11'd1, 11'd1023);
      wait_drained();
      write_threshold(17'd1);
      send_req(frs_pkg::REQ_MOVE, 11'd2, 11'd1);
      send_req(frs_pkg::REQ_MOVE, 11'd1, 11'd512);
   endtask

   task automatic test_out_of_range();
      send_req(frs_pkg::REQ_INSERT, 11'd5, 11'd0);
      send_req(frs_pkg::REQ_INSERT, 11'd5, 11'd1025);
      send_req(frs_pkg::REQ_INSERT, 11'd5, 11'd2047);
      send_req(frs_pkg::REQ_MOVE, 11'd0, 11'd2047);
      send_req(frs_pkg::REQ_MOVE, 11'd1025, 11'd1);
      send_req(frs_pkg::REQ_MOVE, 11'd2047, 11'd0);
   endtask

   task automatic test_underflow();
      wait_drained();
      write_threshold(17'd65535);
      // Bucket 700 is empty; its walk still reaches nodes shared with others.
      send_req(frs_pkg::REQ_MOVE, 11'd700, 11'd512);
      send_req(frs_pkg::REQ_MOVE, 11'd3, 11'd4);
      send_req(frs_pkg::REQ_MOVE, 11'd1023, 11'd1024);
   endtask

   task automatic test_random_phases();
      int p;
      int n;
      int r;
      int idx;
      int span;
      int base;
      int insert_pct;
      int half;
      logic [COUNT_W-1:0] thr;
      logic [BUCKET_W-1:0] dest;
      for (p = 0; p < 10; p++) begin
         wait_drained();
         half = (elem_q.size() + 1) / 2;
         r = $urandom_range(0, 9);
         if (r == 0)
            thr = '0;
         else if (r == 1)
            thr = 17'd65536;
         else if (r == 2)
            thr = COUNT_W'($urandom_range(0, 65536));
         else if (r < 6)
            thr = COUNT_W'(half + $urandom_range(0, 3));
         else
            thr = COUNT_W'(half);
         write_threshold(thr);
         gapless = ($urandom_range(0, 3) == 0);
         insert_pct = (p < 2) ? 80 : $urandom_range(20, 60);
         r = $urandom_range(0, 2);
         span = (r == 0) ? 8 : (r == 1) ? 64 : NUM_BUCKETS;
         base = $urandom_range(1, NUM_BUCKETS + 1 - span);
         for (n = 0; n < 100; n++) begin
            r = $urandom_range(0, 99);
            dest = BUCKET_W'(base + $urandom_range(0, span - 1));
            if (r < 8) begin
               send_req(logic'($urandom_range(0, 1)), BUCKET_W'($urandom_range(0, 2047)),
                        BUCKET_W'($urandom_range(0, 2047)));
            end else if (r < 8 + insert_pct || elem_q.size() == 0) begin
               elem_q = {elem_q, int'(dest)};
               send_req(frs_pkg::REQ_INSERT, BUCKET_W'($urandom_range(0, 2047)), dest);
            end else begin
               idx = $urandom_range(0, elem_q.size() - 1);
               send_req(frs_pkg::REQ_MOVE, BUCKET_W'(elem_q[idx]), dest);
               elem_q[idx] = int'(dest);
            end
         end
      end
      gapless = 1'b0;
   endtask

   task automatic test_crowded_buckets();
      int n;
      wait_drained();
      write_threshold(17'd65536);
      gapless = 1'b1;
      // Two crowded buckets whose update walks meet at node 1024.
      for (n = 0; n < 24; n++)
         send_req(frs_pkg::REQ_INSERT, 11'd0, 11'd512);
      for (n = 0; n < 24; n++)
         send_req(frs_pkg::REQ_INSERT, 11'd0, 11'd768);
      gapless = 1'b0;
      send_req(frs_pkg::REQ_MOVE, 11'd768, 11'd512);
      send_req(frs_pkg::REQ_MOVE, 11'd1024, 11'd769);
      send_req(frs_pkg::REQ_MOVE, 11'd512, 11'd1024);
      wait_drained();
      write_threshold(17'd0);
      send_req(frs_pkg::REQ_MOVE, 11'd1, 11'd768);
      wait_drained();
      write_threshold(17'd1000);
      send_req(frs_pkg::REQ_MOVE, 11'd512, 11'd0);
      send_req(frs_pkg::REQ_MOVE, 11'd0, 11'd1);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (exp_prefix_q.size() == 0) begin
            report_mismatch("result with no move pending", rsp_prefix_count, '0);
         end else begin
            wanted = exp_prefix_q.pop_front();
            if (rsp_prefix_count !== wanted)
               report_mismatch("prefix_count", rsp_prefix_count, wanted);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      for (int i = 1; i <= NUM_BUCKETS; i++)
         fen_nodes[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // The block is still clearing its tree here; the register may be written.
      write_threshold(17'd0);
      test_insert_and_move();
      test_out_of_range();
      test_underflow();
      test_random_phases();
      test_crowded_buckets();
      wait_drained();
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/frs_pkg.sv
rtl/core/fenwick_rank_select.sv
rtl/core/frs_checker.sv
test/tb_fenwick_rank_select.sv
